### rtl/core/ffba_pkg.sv
// shared types and constants of the first-fit block allocator
package ffba_pkg;

   localparam int ENTRIES_DEF      = 64;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int SIZE_W           = 24;
   localparam int ADDR_W           = 32;
   localparam int GROW_W           = 26;
   localparam logic [GROW_W-1:0] PAGE_ROUND = GROW_W'(4095);
   localparam logic [GROW_W-1:0] MIN_GROWTH = GROW_W'(1024 * 1024);
   localparam int CSR_ADDR_W       = 4;

   typedef enum logic [1:0] {
      CMD_ALLOC    = 2'd0,
      CMD_FREE     = 2'd1,
      CMD_REALLOC  = 2'd2,
      CMD_RESERVED = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_DONE     = 3'd0,
      ST_BAD      = 3'd1,
      ST_OOM      = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      REG_HEAP_BASE    = 2'd0,
      REG_INITIAL_SIZE = 2'd1,
      REG_MAX_SIZE     = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic              find_fit;
      logic              wr_en;
      logic              set_free;
      logic              clr_free;
      logic              load;
      logic [SIZE_W-1:0] q_size;
      logic [ADDR_W-1:0] q_addr;
      logic [ADDR_W-1:0] w_addr;
   } cell_ctl_type;

   typedef struct packed {
      logic              hit;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
   } scan_res_type;

endpackage

### rtl/core/ffba_if.sv
// request and response channel interfaces
interface ffba_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] address;
   logic [23:0] byte_count;
   modport source (output valid, cmd, address, byte_count, input ready);
   modport sink (input valid, cmd, address, byte_count, output ready);
endinterface

interface ffba_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] result_address;
   logic [23:0] copy_length;
   modport source (output valid, status, result_address, copy_length, input ready);
   modport sink (input valid, status, result_address, copy_length, output ready);
endinterface

### rtl/core/ffba_cell.sv
// one table entry with its scan token stage
module ffba_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ffba_pkg::cell_ctl_type ctl,
   input  logic                  sel,
   input  logic                  tok_in,
   output logic                  tok,
   output ffba_pkg::scan_res_type res
);
   logic [ffba_pkg::SIZE_W-1:0] size_ff;
   logic [ffba_pkg::ADDR_W-1:0] addr_ff;
   logic                        free_ff;
   logic                        token_ff;
   logic                        match;

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
      end else begin
         token_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sel && ctl.load) begin
         size_ff <= ctl.q_size;
         addr_ff <= ctl.w_addr;
         free_ff <= 1'b0;
      end else if (sel && ctl.set_free) begin
         free_ff <= 1'b1;
      end else if (sel && ctl.clr_free) begin
         free_ff <= 1'b0;
      end
   end

   assign match = ctl.find_fit ? (free_ff && (size_ff >= ctl.q_size))
                               : (addr_ff == ctl.q_addr);
   assign tok      = token_ff;
   assign res.hit  = token_ff && match;
   assign res.size = res.hit ? size_ff : '0;
   assign res.addr = res.hit ? addr_ff : '0;
endmodule

### rtl/core/ffba_chain.sv
// row of table cells with the travelling scan token
module ffba_chain #(
   parameter int ENTRIES = ffba_pkg::ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ffba_pkg::cell_ctl_type     ctl,
   input  logic [$clog2(ENTRIES)-1:0] wr_idx,
   input  logic                       start,
   input  logic                       run,
   output ffba_pkg::scan_res_type     res
);
   localparam int IW = $clog2(ENTRIES);

   logic [ENTRIES-1:0]     tok;
   ffba_pkg::scan_res_type cres [ENTRIES];

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic t_in;
      if (i == 0) begin : g_first
         assign t_in = start;
      end else begin : g_rest
         assign t_in = tok[i-1] && run;
      end
      ffba_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .sel   (ctl.wr_en && (wr_idx == IW'(i))),
         .tok_in(t_in),
         .tok   (tok[i]),
         .res   (cres[i])
      );
   end

   always_comb begin
      res = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         res.hit  = res.hit | cres[i].hit;
         res.size = res.size | cres[i].size;
         res.addr = res.addr | cres[i].addr;
      end
   end

   a_one_token: assert property (@(posedge clock) disable iff (reset) $onehot0(tok))
      else $error("more than one scan token");
endmodule

### rtl/core/first_fit_block_allocator.sv
// top level of the first-fit block allocator
// Requests arrive on req_ch (valid/ready): cmd 0 allocates byte_count bytes, cmd 1
// frees address, cmd 2 reallocates. Each accepted transaction gives exactly one
// response transaction on rsp_ch with status, result_address and copy_length.
// The table is a row of cells; a search token walks one cell per cycle, visiting
// at most the number of entries in use in one scan.
// From acceptance to a valid response an item passes decode, a scan where the
// command needs one, on a miss a heap bump for header and data (S_BUMP1 to S_BUMP4
// each), on reallocate a second scan and the freeing of the old entry, and response.
// One item is worked on at a time; the next is taken at the earliest in the cycle
// after the current result is loaded into the output register, while that result waits.
// If rsp_ch stalls, the result is held and a finished item waits for the register.
// Heap base, initial size and maximum size are written over the APB port; the user
// writes them only while the block is idle, which the block does not enforce. Reset
// (synchronous) empties the table and the heap counters and sets the registers to 0, 0 and all ones.
module first_fit_block_allocator #(
   parameter int ENTRIES      = ffba_pkg::ENTRIES_DEF,
   parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ffba_req_if.sink                        req_ch,
   ffba_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ffba_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int SW = ffba_pkg::SIZE_W;
   localparam int AW = ffba_pkg::ADDR_W;
   localparam int GW = ffba_pkg::GROW_W;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_DECODE = 10'b0000000010,
      S_SCAN   = 10'b0000000100,
      S_BUMP1  = 10'b0000001000,
      S_BUMP2  = 10'b0000010000,
      S_BUMP3  = 10'b0000100000,
      S_BUMP4  = 10'b0001000000,
      S_FREEK  = 10'b0010000000,
      S_RESP   = 10'b0100000000,
      S_PAD    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] base_ff, init_ff, max_ff;
   logic [1:0]  cmd_ff;
   logic [AW-1:0] addr_ff;
   logic [SW-1:0] size_ff, size_in;
   ffba_pkg::status_type st_ff, st_in;
   logic [AW-1:0] res_ff, res_in;
   logic [SW-1:0] copy_ff, copy_in, old_ff, old_in;
   logic [IW-1:0] k_ff, k_in, scan_ff, scan_in;
   logic realloc_ff, realloc_in, fit_ff, fit_in, hdr_ff, hdr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] used_ff, used_in, grown_ff, grown_in;
   logic [32:0] total_ff, total_in, room_ff, room_in;
   logic [GW-1:0] grow_ff, grow_in, need;
   logic needgrow_ff, needgrow_in;
   logic [SW-1:0] n_cur;
   logic cap_fail, ovf, start, run, live, last, csr_wr;
   logic [CW-1:0] scan_next;
   logic [IW-1:0] wr_idx;
   ffba_pkg::cell_ctl_type ctl;
   ffba_pkg::scan_res_type sres;
   logic rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [2:0] rsp_st_ff;
   logic [AW-1:0] rsp_addr_ff;
   logic [SW-1:0] rsp_copy_ff;

   // configuration registers
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         init_ff <= '0;
         max_ff  <= '1;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            ffba_pkg::REG_HEAP_BASE:    base_ff <= pwdata;
            ffba_pkg::REG_INITIAL_SIZE: init_ff <= pwdata;
            ffba_pkg::REG_MAX_SIZE:     max_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         ffba_pkg::REG_HEAP_BASE:    prdata = base_ff;
         ffba_pkg::REG_INITIAL_SIZE: prdata = init_ff;
         ffba_pkg::REG_MAX_SIZE:     prdata = max_ff;
         default:                    prdata = '0;
      endcase
   end

   ffba_chain #(.ENTRIES(ENTRIES)) u_chain (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .wr_idx(wr_idx),
      .start (start),
      .run   (run),
      .res   (sres)
   );

   assign n_cur     = hdr_ff ? SW'(HEADER_BYTES) : size_ff;
   assign scan_next = CW'(scan_ff) + CW'(1);
   assign live      = CW'(scan_ff) < count_ff;
   assign last      = scan_next == count_ff;
   assign run       = (state_ff == S_SCAN) && live && !sres.hit && !last;
   assign need      = (GW'(n_cur) - room_ff[GW-1:0] + ffba_pkg::PAGE_ROUND)
                      & ~ffba_pkg::PAGE_ROUND;
   assign cap_fail  = needgrow_ff && (({1'b0, total_ff} + 34'(grow_ff)) > {2'b0, max_ff});
   assign ovf       = ({1'b0, used_ff} + 33'(n_cur)) > 33'hFFFFFFFF;

   always_comb begin
      state_in    = state_ff;
      size_in     = size_ff;
      st_in       = st_ff;
      res_in      = res_ff;
      copy_in     = copy_ff;
      old_in      = old_ff;
      k_in        = k_ff;
      scan_in     = scan_ff;
      realloc_in  = realloc_ff;
      fit_in      = fit_ff;
      hdr_in      = hdr_ff;
      count_in    = count_ff;
      used_in     = used_ff;
      grown_in    = grown_ff;
      total_in    = total_ff;
      room_in     = room_ff;
      grow_in     = grow_ff;
      needgrow_in = needgrow_ff;
      start       = 1'b0;
      wr_idx      = scan_ff;
      rsp_load    = 1'b0;
      ctl.find_fit = fit_ff;
      ctl.wr_en    = 1'b0;
      ctl.set_free = 1'b0;
      ctl.clr_free = 1'b0;
      ctl.load     = 1'b0;
      ctl.q_size   = size_ff;
      ctl.q_addr   = addr_ff;
      ctl.w_addr   = base_ff + used_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               size_in  = req_ch.byte_count;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in     = '0;
            copy_in    = '0;
            st_in      = ffba_pkg::ST_DONE;
            realloc_in = 1'b0;
            scan_in    = '0;
            state_in   = S_RESP;
            priority if (cmd_ff == ffba_pkg::CMD_ALLOC
                         || (cmd_ff == ffba_pkg::CMD_REALLOC && addr_ff == '0)) begin
               if (size_ff == '0) begin
                  st_in = ffba_pkg::ST_BAD;
               end else begin
                  fit_in   = 1'b1;
                  start    = 1'b1;
                  state_in = S_SCAN;
               end
            end else if (cmd_ff == ffba_pkg::CMD_FREE || cmd_ff == ffba_pkg::CMD_REALLOC) begin
               if (addr_ff != '0) begin
                  realloc_in = (cmd_ff == ffba_pkg::CMD_REALLOC) && (size_ff != '0);
                  fit_in     = 1'b0;
                  start      = 1'b1;
                  state_in   = S_SCAN;
               end
            end else begin
               st_in = ffba_pkg::ST_BAD;
            end
         end
         S_SCAN: begin
            if (live && sres.hit) begin
               if (!fit_ff) begin
                  k_in   = scan_ff;
                  old_in = sres.size;
                  if (realloc_ff) begin
                     fit_in   = 1'b1;
                     scan_in  = '0;
                     start    = 1'b1;
                  end else begin
                     ctl.wr_en    = 1'b1;
                     ctl.set_free = 1'b1;
                     state_in     = S_RESP;
                  end
               end else begin
                  ctl.wr_en    = 1'b1;
                  ctl.clr_free = 1'b1;
                  res_in       = sres.addr;
                  state_in     = realloc_ff ? S_FREEK : S_RESP;
               end
            end else if (!live || last) begin
               if (!fit_ff) begin
                  st_in    = ffba_pkg::ST_NOTFOUND;
                  state_in = S_RESP;
               end else if (count_ff == CW'(ENTRIES)) begin
                  st_in    = ffba_pkg::ST_FULL;
                  state_in = S_RESP;
               end else begin
                  hdr_in   = HEADER_BYTES > 0;
                  state_in = S_BUMP1;
               end
            end else begin
               scan_in = scan_next[IW-1:0];
            end
         end
         S_BUMP1: begin
            total_in = {1'b0, init_ff} + {1'b0, grown_ff};
            state_in = S_BUMP2;
         end
         S_BUMP2: begin
            room_in  = (total_ff > {1'b0, used_ff}) ? total_ff - {1'b0, used_ff} : '0;
            state_in = S_BUMP3;
         end
         S_BUMP3: begin
            needgrow_in = room_ff <= 33'(n_cur);
            grow_in     = (need < ffba_pkg::MIN_GROWTH) ? ffba_pkg::MIN_GROWTH : need;
            state_in    = S_BUMP4;
         end
         S_BUMP4: begin
            if (cap_fail) begin
               st_in    = ffba_pkg::ST_OOM;
               state_in = S_RESP;
            end else begin
               if (needgrow_ff) begin
                  grown_in = grown_ff + 32'(grow_ff);
               end
               if (ovf) begin
                  st_in    = ffba_pkg::ST_OOM;
                  state_in = S_RESP;
               end else begin
                  used_in = used_ff + 32'(n_cur);
                  if (hdr_ff) begin
                     hdr_in   = 1'b0;
                     state_in = S_BUMP1;
                  end else begin
                     wr_idx   = count_ff[IW-1:0];
                     ctl.wr_en = 1'b1;
                     ctl.load  = 1'b1;
                     count_in = count_ff + CW'(1);
                     res_in   = base_ff + used_ff;
                     state_in = realloc_ff ? S_FREEK : S_RESP;
                  end
               end
            end
         end
         S_FREEK: begin
            wr_idx       = k_ff;
            ctl.wr_en    = 1'b1;
            ctl.set_free = 1'b1;
            copy_in      = (old_ff < size_ff) ? old_ff : size_ff;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         grown_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fit_ff       <= 1'b0;
         hdr_ff       <= 1'b0;
         realloc_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         grown_ff     <= grown_in;
         rsp_valid_ff <= rsp_valid_in;
         fit_ff       <= fit_in;
         hdr_ff       <= hdr_in;
         realloc_ff   <= realloc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_ch.valid) begin
         cmd_ff  <= req_ch.cmd;
         addr_ff <= req_ch.address;
      end
      size_ff     <= size_in;
      st_ff       <= st_in;
      res_ff      <= res_in;
      copy_ff     <= copy_in;
      old_ff      <= old_in;
      k_ff        <= k_in;
      scan_ff     <= scan_in;
      total_ff    <= total_in;
      room_ff     <= room_in;
      grow_ff     <= grow_in;
      needgrow_ff <= needgrow_in;
      if (rsp_load) begin
         rsp_st_ff   <= st_ff;
         rsp_addr_ff <= (st_ff == ffba_pkg::ST_DONE) ? res_ff : '0;
         rsp_copy_ff <= copy_ff;
      end
   end

   assign req_ch.ready          = state_ff == S_IDLE;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_st_ff;
   assign rsp_ch.result_address = rsp_addr_ff;
   assign rsp_ch.copy_length    = rsp_copy_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES)) else $error("table count beyond capacity");
   a_used_grows: assert property (@(posedge clock) disable iff (reset)
      !reset |=> used_ff >= $past(used_ff)) else $error("used bytes went down");
   a_grown_grows: assert property (@(posedge clock) disable iff (reset)
      !reset |=> grown_ff >= $past(grown_ff)) else $error("grown bytes went down");
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> state_ff == S_DECODE)
      else $error("transaction accepted without decode");
endmodule

### test/ffba_checker.sv
// checker for the first-fit block allocator: predicts responses from request transactions
`timescale 1ns / 100ps
module ffba_checker #(
   parameter int ENTRIES      = ffba_pkg::ENTRIES_DEF,
   parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [31:0]           req_address,
   input  logic [23:0]           req_byte_count,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [2:0]            rsp_status,
   input  logic [31:0]           rsp_result_address,
   input  logic [23:0]           rsp_copy_length,
   input  logic                  cfg_we,
   input  ffba_pkg::reg_idx_type cfg_idx,
   input  logic [31:0]           cfg_value,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct packed {
      ffba_pkg::status_type status;
      logic [31:0]          address;
      logic [23:0]          copy;
   } outcome_type;

   logic [31:0] heap_base, initial_size, max_size;
   logic [23:0] size_tab [ENTRIES];
   logic [31:0] addr_tab [ENTRIES];
   logic        free_tab [ENTRIES];
   int          entry_count;
   logic [31:0] used_bytes, grown_bytes;
   outcome_type awaited [$];

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic ffba_pkg::status_type bump(input logic [31:0] n, output logic [31:0] a);
      logic [63:0] total, room, grow;
      total = 64'(initial_size) + 64'(grown_bytes);
      room  = (total > 64'(used_bytes)) ? total - 64'(used_bytes) : 64'd0;
      if (room <= 64'(n)) begin
         grow = (64'(n) - room + 64'd4095) & ~64'd4095;
         if (grow < 64'(1024 * 1024)) grow = 64'(1024 * 1024);
         if (total + grow > 64'(max_size)) return ffba_pkg::ST_OOM;
         grown_bytes = grown_bytes + grow[31:0];
      end
      if (64'(used_bytes) + 64'(n) > 64'hFFFF_FFFF) return ffba_pkg::ST_OOM;
      a = heap_base + used_bytes;
      used_bytes = used_bytes + n;
      return ffba_pkg::ST_DONE;
   endfunction

   function automatic int lookup(input logic [31:0] a);
      for (int i = 0; i < entry_count; i++)
         if (addr_tab[i] == a) return i;
      return -1;
   endfunction

   function automatic ffba_pkg::status_type claim(input logic [23:0] sz,
                                                  output logic [31:0] a);
      logic [31:0]          hdr, dat;
      ffba_pkg::status_type st;
      if (sz == 0) return ffba_pkg::ST_BAD;
      for (int i = 0; i < entry_count; i++)
         if (free_tab[i] && size_tab[i] >= sz) begin
            free_tab[i] = 1'b0;
            a = addr_tab[i];
            return ffba_pkg::ST_DONE;
         end
      if (entry_count >= ENTRIES) return ffba_pkg::ST_FULL;
      if (HEADER_BYTES > 0) begin
         st = bump(32'(HEADER_BYTES), hdr);
         if (st != ffba_pkg::ST_DONE) return st;
      end
      st = bump(32'(sz), dat);
      if (st != ffba_pkg::ST_DONE) return st;
      size_tab[entry_count] = sz;
      addr_tab[entry_count] = dat;
      free_tab[entry_count] = 1'b0;
      entry_count++;
      a = dat;
      return ffba_pkg::ST_DONE;
   endfunction

   function automatic ffba_pkg::status_type release_addr(input logic [31:0] a);
      int k;
      if (a == 0) return ffba_pkg::ST_DONE;
      k = lookup(a);
      if (k < 0) return ffba_pkg::ST_NOTFOUND;
      free_tab[k] = 1'b1;
      return ffba_pkg::ST_DONE;
   endfunction

   function automatic outcome_type predict(input logic [1:0] cmd, input logic [31:0] a,
                                           input logic [23:0] sz);
      outcome_type o;
      int          k;
      logic [23:0] old;
      o.status  = ffba_pkg::ST_BAD;
      o.address = '0;
      o.copy    = '0;
      case (cmd)
         ffba_pkg::CMD_ALLOC: o.status = claim(sz, o.address);
         ffba_pkg::CMD_FREE: o.status = release_addr(a);
         ffba_pkg::CMD_REALLOC: begin
            if (a == 0) o.status = claim(sz, o.address);
            else if (sz == 0) o.status = release_addr(a);
            else begin
               k = lookup(a);
               if (k < 0) o.status = ffba_pkg::ST_NOTFOUND;
               else begin
                  old = size_tab[k];
                  o.status = claim(sz, o.address);
                  if (o.status == ffba_pkg::ST_DONE) begin
                     o.copy = (old < sz) ? old : sz;
                     free_tab[k] = 1'b1;
                  end
               end
            end
         end
         default: o.status = ffba_pkg::ST_BAD;
      endcase
      if (o.status != ffba_pkg::ST_DONE) o.address = '0;
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type w;
      if (reset) begin
         heap_base    = '0;
         initial_size = '0;
         max_size     = '1;
         entry_count  = 0;
         used_bytes   = '0;
         grown_bytes  = '0;
         awaited.delete();
      end else begin
         if (cfg_we) begin
            case (cfg_idx)
               ffba_pkg::REG_HEAP_BASE: heap_base = cfg_value;
               ffba_pkg::REG_INITIAL_SIZE: initial_size = cfg_value;
               ffba_pkg::REG_MAX_SIZE: max_size = cfg_value;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) report("unexpected response", 64'd0, 64'd0);
            else begin
               w = awaited.pop_front();
               if (rsp_status != w.status)
                  report("status", 64'(rsp_status), 64'(w.status));
               if (rsp_result_address != w.address)
                  report("result_address", 64'(rsp_result_address), 64'(w.address));
               if (rsp_copy_length != w.copy)
                  report("copy_length", 64'(rsp_copy_length), 64'(w.copy));
            end
         end
         if (req_valid && req_ready)
            awaited.push_back(predict(req_cmd, req_address, req_byte_count));
      end
      pending_count = awaited.size();
   end

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

endmodule

### test/tb.sv
// testbench top: stimulus, configuration writes and verdict for the block allocator
`timescale 1ns / 100ps
module tb;

   localparam int LIMIT = 600000;

   logic        clock = 0;
   logic        reset = 1;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [ffba_pkg::CSR_ADDR_W-1:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;
   logic        pready;
   int          fail_count, pending_count;
   int          cycles = 0;
   logic [31:0] handed [$];

   ffba_req_if req_ch ();
   ffba_rsp_if rsp_ch ();

   first_fit_block_allocator dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   ffba_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_cmd(req_ch.cmd),
      .req_address(req_ch.address), .req_byte_count(req_ch.byte_count),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_status(rsp_ch.status),
      .rsp_result_address(rsp_ch.result_address), .rsp_copy_length(rsp_ch.copy_length),
      .cfg_we(psel && penable && pwrite && pready),
      .cfg_idx(ffba_pkg::reg_idx_type'(paddr[3:2])), .cfg_value(pwdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.cmd = ffba_pkg::CMD_ALLOC;
      req_ch.address = 0;
      req_ch.byte_count = 0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // handed-out addresses are remembered so free and reallocate hit real entries
   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready && rsp_ch.result_address != 0)
         handed.push_back(rsp_ch.result_address);

   always @(posedge clock) begin
      int gap;
      if (reset) rsp_ch.ready <= 0;
      else if (gap > 0) begin
         gap--;
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= 1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
               gap--;
               rsp_ch.ready <= 0;
            end
         end
      end
   end

   task automatic csr_write(input ffba_pkg::reg_idx_type idx, input logic [31:0] v);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= ffba_pkg::CSR_ADDR_W'(idx) << 2; pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic send(input ffba_pkg::cmd_type c, input logic [31:0] a,
                       input logic [23:0] sz, input bit idle_gaps);
      int gap;
      gap = idle_gaps ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.cmd <= c;
      req_ch.address <= a;
      req_ch.byte_count <= sz;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain;
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (160) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_addr();
      if (handed.size() == 0 || $urandom_range(0, 9) == 0) return $urandom;
      return handed[$urandom_range(0, handed.size() - 1)];
   endfunction

   function automatic logic [23:0] pick_size();
      case ($urandom_range(0, 9))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return 24'(1) << $urandom_range(0, 23);
         3: return 24'($urandom);
         default: return 24'($urandom_range(1, 300));
      endcase
   endfunction

   task automatic random_phase(input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 19);
         if (r < 9) send(ffba_pkg::CMD_ALLOC, $urandom, pick_size(), 1);
         else if (r < 14) send(ffba_pkg::CMD_FREE, pick_addr(), 24'($urandom), 1);
         else if (r < 19)
            send(ffba_pkg::CMD_REALLOC, (r == 18) ? 32'd0 : pick_addr(), pick_size(), 1);
         else send(ffba_pkg::CMD_RESERVED, $urandom, 24'($urandom), 1);
      end
   endtask

   initial begin
      logic [31:0] a;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(ffba_pkg::CMD_ALLOC, 0, 0, 0);
      send(ffba_pkg::CMD_ALLOC, 0, 24'd1, 0);
      send(ffba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 24'hFFFFFF, 0);
      send(ffba_pkg::CMD_ALLOC, 0, 24'd100, 0);
      send(ffba_pkg::CMD_RESERVED, 32'hFFFF_FFFF, 24'hFFFFFF, 0);
      send(ffba_pkg::CMD_FREE, 0, 0, 0);
      send(ffba_pkg::CMD_FREE, 32'hDEAD_BEE0, 0, 0);
      drain();
      a = handed.size() ? handed[0] : 0;
      send(ffba_pkg::CMD_FREE, a, 0, 0);
      send(ffba_pkg::CMD_FREE, a, 0, 0);
      send(ffba_pkg::CMD_ALLOC, 0, 24'd1, 0);
      send(ffba_pkg::CMD_REALLOC, 0, 24'd50, 0);
      send(ffba_pkg::CMD_REALLOC, 32'h1234_5670, 24'd8, 0);
      drain();
      a = handed[handed.size() - 1];
      send(ffba_pkg::CMD_REALLOC, a, 24'd10, 0);
      send(ffba_pkg::CMD_REALLOC, a, 24'd0, 0);
      send(ffba_pkg::CMD_REALLOC, a, 24'd40, 0);
      send(ffba_pkg::CMD_REALLOC, a, 24'hFFFFFF, 0);
      drain();

      // tight heap: growth capped at a maximum size of 2000000 bytes
      csr_write(ffba_pkg::REG_HEAP_BASE, 32'hFFFF_FF00);
      csr_write(ffba_pkg::REG_INITIAL_SIZE, 32'd64);
      csr_write(ffba_pkg::REG_MAX_SIZE, 32'd2000000);
      random_phase(200);
      drain();

      // no growth possible at all
      csr_write(ffba_pkg::REG_MAX_SIZE, 32'd0);
      csr_write(ffba_pkg::REG_INITIAL_SIZE, 32'd0);
      csr_write(ffba_pkg::REG_HEAP_BASE, 32'h0);
      random_phase(100);
      drain();

      // large heap, fill the table
      csr_write(ffba_pkg::REG_HEAP_BASE, $urandom);
      csr_write(ffba_pkg::REG_INITIAL_SIZE, 32'hFFFF_FFFF);
      csr_write(ffba_pkg::REG_MAX_SIZE, 32'hFFFF_FFFF);
      for (int i = 0; i < 70; i++)
         send(ffba_pkg::CMD_ALLOC, 0, 24'($urandom_range(1, 64)), 1);
      random_phase(250);
      drain();

      csr_write(ffba_pkg::REG_HEAP_BASE, $urandom);
      csr_write(ffba_pkg::REG_INITIAL_SIZE, $urandom);
      csr_write(ffba_pkg::REG_MAX_SIZE, $urandom);
      random_phase(200);
      drain();

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/ffba_pkg.sv
rtl/core/ffba_if.sv
rtl/core/ffba_cell.sv
rtl/core/ffba_chain.sv
rtl/core/first_fit_block_allocator.sv
test/ffba_checker.sv
test/tb.sv
